/* rtl/core/event_interest_table_core_macros.svh */
// Assertion macros for the event interest table core.
`ifndef EVENT_INTEREST_TABLE_CORE_MACROS_SVH
`define EVENT_INTEREST_TABLE_CORE_MACROS_SVH

// check cons in the same cycle as ante
`define EIT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define EIT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/eit_pkg.sv */
// Shared types and constants of the event interest table core.
package eit_pkg;

	localparam int SLOTS_DEF  = 32;
	localparam int FD_COUNT   = 64;
	localparam int MAX_REPORT = 32;
	localparam int FD_W       = 6;
	localparam int PADDR_W    = 3;

	localparam logic [2:0] ACT_SCAN = 3'd0;
	localparam logic [2:0] ACT_ADD  = 3'd1;
	localparam logic [2:0] ACT_DEL  = 3'd2;
	localparam logic [2:0] ACT_MOD  = 3'd3;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_BADFD = 3'd1;
	localparam logic [2:0] STAT_INVAL = 3'd2;
	localparam logic [2:0] STAT_EXIST = 3'd3;
	localparam logic [2:0] STAT_NOENT = 3'd4;
	localparam logic [2:0] STAT_NOSPC = 3'd5;

	localparam logic REG_OWN_FD = 1'b0;

	typedef struct packed {
		logic [2:0]      action;
		logic [FD_W-1:0] fd;
		logic            fd_open;
		logic [31:0]     want_events;
		logic [63:0]     user_data;
		logic [63:0]     readable_map;
		logic [63:0]     writable_map;
		logic [5:0]      max_events;
	} eit_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [2:0]  event_mask;
		logic [63:0] event_data;
		logic [5:0]  event_count;
		logic        last;
	} eit_result_t;

	typedef struct packed {
		logic            valid;
		logic [FD_W-1:0] fd;
		logic            want_rd;
		logic            want_wr;
		logic [63:0]     data;
	} eit_entry_t;

	typedef struct packed {
		logic            write;
		logic            set_valid;
		logic            clear_valid;
		logic [FD_W-1:0] fd;
		logic            want_rd;
		logic            want_wr;
		logic [63:0]     data;
	} eit_wr_t;

endpackage

/* rtl/core/eit_table.sv */
// Entry store: valid flags in flops, descriptor, wanted bits and user data in memory.
module eit_table #(
	parameter int SLOTS = eit_pkg::SLOTS_DEF,
	parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IW-1:0]      rd_addr,
	output eit_pkg::eit_entry_t rd_entry,
	input  logic [IW-1:0]      wr_addr,
	input  eit_pkg::eit_wr_t   wr
);

	logic [SLOTS-1:0]       valid_q;
	logic [eit_pkg::FD_W-1:0] fd_mem [SLOTS];
	logic [1:0]             want_mem [SLOTS];
	logic [63:0]            data_mem [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set_valid) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (wr.clear_valid) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.write) begin
			fd_mem[wr_addr]   <= wr.fd;
			want_mem[wr_addr] <= {wr.want_wr, wr.want_rd};
			data_mem[wr_addr] <= wr.data;
		end
		rd_entry.valid   <= valid_q[rd_addr];
		rd_entry.fd      <= fd_mem[rd_addr];
		rd_entry.want_rd <= want_mem[rd_addr][0];
		rd_entry.want_wr <= want_mem[rd_addr][1];
		rd_entry.data    <= data_mem[rd_addr];
	end

endmodule

/* rtl/core/event_interest_table_core.sv */
// Top level of the event interest table core: command sequencer and config port.
//
// Use: hold cmd and raise start while busy is low; the word is taken at that edge.
// Add, delete and modify are keyed by cmd.fd; scan uses the two readiness maps
// and max_events. Every word gives results on result, each marked by a single
// cycle of result_valid; the final one of a word carries last.
// A command rejected by the descriptor or action checks, and a scan with
// max_events of zero, answer in the cycle after acceptance and leave busy low.
// Any other word walks the entry store once, one entry per cycle through the
// single read port; the final result appears in the first cycle with busy low.
// A keyed command that finds its descriptor, or a scan that fills max_events,
// ends the walk early.
// Event words come out in entry order during the walk. No new word is taken
// until the last one is through. own_fd is set via APB at byte address 0;
// the user must do so only while idle, which the block does not check.
// Reset clears all entries and own_fd; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "event_interest_table_core_macros.svh"

module event_interest_table_core #(
	parameter int SLOTS = eit_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  eit_pkg::eit_cmd_t             cmd,
	output logic                          result_valid,
	output eit_pkg::eit_result_t          result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [eit_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_CLOSE
	} state_t;

	state_t                   state_q;
	logic                     result_valid_q;
	eit_pkg::eit_result_t     result_q;
	logic [eit_pkg::FD_W-1:0] own_fd_q;

	logic [2:0]               act_q;
	logic                     is_scan_q;
	logic [eit_pkg::FD_W-1:0] fd_q;
	logic                     want_rd_q;
	logic                     want_wr_q;
	logic [63:0]              data_q;
	logic [63:0]              rmap_q;
	logic [63:0]              wmap_q;
	logic [5:0]               maxev_q;
	logic [5:0]               n_q;
	logic [CW-1:0]            cnt_q;
	logic                     issued_s1;
	logic [IW-1:0]            idx_s1;
	logic                     free_found_q;
	logic [IW-1:0]            free_q;

	eit_pkg::eit_entry_t      rd;
	eit_pkg::eit_wr_t         wr;
	logic [IW-1:0]            wr_addr;

	logic                     walk_more;
	logic                     walk_end;
	logic                     hit_rd;
	logic                     hit_wr;
	logic                     ev_hit;
	logic                     match;
	logic                     free_slot;
	logic                     cfg_wr;
	logic                     fd_bad;

	function automatic eit_pkg::eit_result_t mk_result(
		input logic        kind,
		input logic [2:0]  status,
		input logic [2:0]  mask,
		input logic [63:0] data,
		input logic [5:0]  count,
		input logic        last
	);
		eit_pkg::eit_result_t r;
		r.kind        = kind;
		r.status      = status;
		r.event_mask  = mask;
		r.event_data  = data;
		r.event_count = count;
		r.last        = last;
		return r;
	endfunction

	eit_table #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (cnt_q[IW-1:0]),
		.rd_entry (rd),
		.wr_addr  (wr_addr),
		.wr       (wr)
	);

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;

	assign cfg_wr = psel && penable && pwrite && (paddr[eit_pkg::PADDR_W-1:2] == eit_pkg::REG_OWN_FD);
	assign prdata = (paddr[eit_pkg::PADDR_W-1:2] == eit_pkg::REG_OWN_FD) ?
		{26'd0, own_fd_q} : 32'd0;

	assign fd_bad = ({1'b0, cmd.fd} >= 7'(eit_pkg::FD_COUNT)) || !cmd.fd_open;

	always_comb begin
		walk_more = (cnt_q < CW'(SLOTS));
		walk_end  = !issued_s1 && !walk_more;
		hit_rd    = rd.want_rd && rmap_q[rd.fd];
		hit_wr    = rd.want_wr && wmap_q[rd.fd];
		ev_hit    = issued_s1 && rd.valid && (hit_rd || hit_wr);
		match     = issued_s1 && rd.valid && (rd.fd == fd_q);
		free_slot = issued_s1 && !rd.valid;

		wr             = '0;
		wr.fd          = fd_q;
		wr.want_rd     = want_rd_q;
		wr.want_wr     = want_wr_q;
		wr.data        = data_q;
		wr_addr        = idx_s1;
		if (state_q == S_WALK && !is_scan_q) begin
			if (match) begin
				wr.clear_valid = (act_q == eit_pkg::ACT_DEL);
				wr.write       = (act_q == eit_pkg::ACT_MOD);
			end else if (walk_end && act_q == eit_pkg::ACT_ADD && free_found_q) begin
				wr.write     = 1'b1;
				wr.set_valid = 1'b1;
				wr_addr      = free_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_fd_q <= '0;
		end else if (cfg_wr) begin
			own_fd_q <= pwdata[eit_pkg::FD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			issued_s1      <= 1'b0;
			cnt_q          <= '0;
			n_q            <= '0;
			free_found_q   <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q        <= cmd.action;
						is_scan_q    <= (cmd.action == eit_pkg::ACT_SCAN);
						fd_q         <= cmd.fd;
						want_rd_q    <= cmd.want_events[0];
						want_wr_q    <= cmd.want_events[2];
						data_q       <= cmd.user_data;
						rmap_q       <= cmd.readable_map;
						wmap_q       <= cmd.writable_map;
						maxev_q      <= (cmd.max_events > 6'(eit_pkg::MAX_REPORT)) ?
							6'(eit_pkg::MAX_REPORT) : cmd.max_events;
						cnt_q        <= '0;
						issued_s1    <= 1'b0;
						n_q          <= '0;
						free_found_q <= 1'b0;
						if (cmd.action == eit_pkg::ACT_SCAN) begin
							if (cmd.max_events == 6'd0) begin
								result_valid_q <= 1'b1;
								result_q <= mk_result(1'b0, eit_pkg::STAT_INVAL, 3'd0, 64'd0,
									6'd0, 1'b1);
							end else begin
								state_q <= S_WALK;
							end
						end else if (fd_bad) begin
							result_valid_q <= 1'b1;
							result_q <= mk_result(1'b0, eit_pkg::STAT_BADFD, 3'd0, 64'd0,
								6'd0, 1'b1);
						end else if (cmd.fd == own_fd_q || cmd.action > eit_pkg::ACT_MOD) begin
							result_valid_q <= 1'b1;
							result_q <= mk_result(1'b0, eit_pkg::STAT_INVAL, 3'd0, 64'd0,
								6'd0, 1'b1);
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (walk_more) begin
						cnt_q     <= cnt_q + CW'(1);
						idx_s1    <= cnt_q[IW-1:0];
						issued_s1 <= 1'b1;
					end else begin
						issued_s1 <= 1'b0;
					end
					if (is_scan_q) begin
						if (ev_hit) begin
							result_valid_q <= 1'b1;
							result_q <= mk_result(1'b1, eit_pkg::STAT_OK, {hit_wr, 1'b0, hit_rd},
								rd.data, n_q, 1'b0);
							n_q <= n_q + 6'd1;
							if (6'(n_q + 6'd1) == maxev_q) begin
								state_q <= S_CLOSE;
							end
						end else if (walk_end) begin
							result_valid_q <= 1'b1;
							result_q <= mk_result(1'b0, eit_pkg::STAT_OK, 3'd0, 64'd0, n_q, 1'b1);
							state_q  <= S_IDLE;
						end
					end else begin
						if (match) begin
							result_valid_q <= 1'b1;
							result_q <= mk_result(1'b0,
								(act_q == eit_pkg::ACT_ADD) ? eit_pkg::STAT_EXIST : eit_pkg::STAT_OK,
								3'd0, 64'd0, 6'd0, 1'b1);
							state_q <= S_IDLE;
						end else if (walk_end) begin
							result_valid_q <= 1'b1;
							if (act_q != eit_pkg::ACT_ADD) begin
								result_q <= mk_result(1'b0, eit_pkg::STAT_NOENT, 3'd0, 64'd0,
									6'd0, 1'b1);
							end else if (!free_found_q) begin
								result_q <= mk_result(1'b0, eit_pkg::STAT_NOSPC, 3'd0, 64'd0,
									6'd0, 1'b1);
							end else begin
								result_q <= mk_result(1'b0, eit_pkg::STAT_OK, 3'd0, 64'd0,
									6'd0, 1'b1);
							end
							state_q <= S_IDLE;
						end else if (free_slot && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q       <= idx_s1;
						end
					end
				end
				S_CLOSE: begin
					result_valid_q <= 1'b1;
					result_q <= mk_result(1'b0, eit_pkg::STAT_OK, 3'd0, 64'd0, n_q, 1'b1);
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`EIT_ASSERT_SAME(a_last_when_idle, result_valid && result.last, !busy, "last word while busy")
	`EIT_ASSERT_SAME(a_event_not_last, result_valid && result.kind, !result.last, "event marked last")
	`EIT_ASSERT_SAME(a_event_below_max, result_valid && result.kind, result.event_count < maxev_q,
		"event count beyond max_events")
	`EIT_ASSERT_NEXT(a_quiet_idle, !busy && !start, !result_valid, "result without a word")

endmodule

/* sim/tb.sv */
// Self-checking testbench for the event interest table core: directed and random words.
module tb;
	import eit_pkg::*;

	localparam logic [2:0] ACT_UNSUP  = 3'd4;
	localparam logic       KIND_PLAIN = 1'b0;
	localparam logic       KIND_EVENT = 1'b1;
	localparam logic [2:0] EV_READ    = 3'b001;
	localparam logic [2:0] EV_WRITE   = 3'b100;
	localparam int         SETTLE_CYC = 40;
	localparam int         PHASES     = 8;
	localparam int         PHASE_LEN  = 54;

	typedef enum logic [1:0] {JOB_WORD, JOB_OWN_FD, JOB_DRAIN} job_op_t;

	typedef struct {
		job_op_t     op;
		eit_cmd_t    word;
		int          gap;
		logic [31:0] reg_val;
	} job_t;

	logic        clk;
	logic        arst_n;
	logic        start = 1'b0;
	logic        busy;
	eit_cmd_t    cmd = '0;
	logic        result_valid;
	eit_result_t result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	job_t        jobs_q[$];
	eit_result_t answers_q[$];
	eit_result_t head;
	int          mismatches = 0;
	int          hold_off;
	int          settle;

	logic              slot_valid[SLOTS_DEF];
	logic [FD_W-1:0]   slot_fd[SLOTS_DEF];
	logic [31:0]       slot_mask[SLOTS_DEF];
	logic [63:0]       slot_data[SLOTS_DEF];
	logic [FD_W-1:0]   own_fd_now;

	event_interest_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic eit_result_t plain_answer(logic [2:0] st, logic [5:0] count);
		eit_result_t a;
		a = '0;
		a.kind = KIND_PLAIN;
		a.status = st;
		a.event_count = count;
		a.last = 1'b1;
		return a;
	endfunction

	function automatic logic [2:0] command_status(eit_cmd_t w);
		int hit;
		int vacant;
		hit = -1;
		vacant = -1;
		if (int'(w.fd) >= FD_COUNT || !w.fd_open)
			return STAT_BADFD;
		if (w.fd == own_fd_now)
			return STAT_INVAL;
		if (w.action != ACT_ADD && w.action != ACT_DEL && w.action != ACT_MOD)
			return STAT_INVAL;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (!slot_valid[i]) begin
				if (vacant < 0)
					vacant = i;
			end else if (hit < 0 && slot_fd[i] == w.fd) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			case (w.action)
			ACT_DEL: begin
				slot_valid[hit] = 1'b0;
				return STAT_OK;
			end
			ACT_ADD: return STAT_EXIST;
			default: begin
				slot_mask[hit] = w.want_events;
				slot_data[hit] = w.user_data;
				return STAT_OK;
			end
			endcase
		end
		if (w.action != ACT_ADD)
			return STAT_NOENT;
		if (vacant < 0)
			return STAT_NOSPC;
		slot_valid[vacant] = 1'b1;
		slot_fd[vacant] = w.fd;
		slot_mask[vacant] = w.want_events;
		slot_data[vacant] = w.user_data;
		return STAT_OK;
	endfunction

	function automatic void apply_word(eit_cmd_t w);
		int lim;
		int n;
		logic [2:0] ev;
		eit_result_t a;
		if (w.action != ACT_SCAN) begin
			answers_q.push_back(plain_answer(command_status(w), 6'd0));
			return;
		end
		lim = int'(w.max_events);
		if (lim == 0) begin
			answers_q.push_back(plain_answer(STAT_INVAL, 6'd0));
			return;
		end
		if (lim > MAX_REPORT)
			lim = MAX_REPORT;
		n = 0;
		for (int i = 0; i < SLOTS_DEF && n < lim; i++) begin
			if (slot_valid[i]) begin
				ev = '0;
				if (slot_mask[i][0] && w.readable_map[slot_fd[i]])
					ev |= EV_READ;
				if (slot_mask[i][2] && w.writable_map[slot_fd[i]])
					ev |= EV_WRITE;
				if (ev != '0) begin
					a = '0;
					a.kind = KIND_EVENT;
					a.status = STAT_OK;
					a.event_mask = ev;
					a.event_data = slot_data[i];
					a.event_count = 6'(n);
					answers_q.push_back(a);
					n++;
				end
			end
		end
		answers_q.push_back(plain_answer(STAT_OK, 6'(n)));
	endfunction

	// driver: words from jobs_q, register writes only once the block has gone quiet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= '0;
			pwdata <= '0;
			hold_off <= 0;
			settle <= 0;
		end else begin
			if (start && !busy)
				apply_word(cmd);
			if (psel && penable && pwrite && pready) begin
				own_fd_now = pwdata[FD_W-1:0];
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				void'(jobs_q.pop_front());
			end else if (psel) begin
				penable <= 1'b1;
			end else if (start && busy) begin
				start <= 1'b1;
			end else if (hold_off != 0) begin
				start <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (jobs_q.size() == 0) begin
				start <= 1'b0;
			end else if (jobs_q[0].op == JOB_WORD) begin
				start <= 1'b1;
				cmd <= jobs_q[0].word;
				hold_off <= jobs_q[0].gap;
				void'(jobs_q.pop_front());
			end else begin
				start <= 1'b0;
				if (answers_q.size() == 0 && !busy && !result_valid) begin
					if (settle >= SETTLE_CYC) begin
						settle <= 0;
						if (jobs_q[0].op == JOB_DRAIN) begin
							void'(jobs_q.pop_front());
						end else begin
							psel <= 1'b1;
							pwrite <= 1'b1;
							paddr <= {REG_OWN_FD, 2'b00};
							pwdata <= jobs_q[0].reg_val;
						end
					end else begin
						settle <= settle + 1;
					end
				end else begin
					settle <= 0;
				end
			end
		end
	end

	task automatic log_mismatch(string what, eit_result_t want, eit_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: want kind=%0d st=%0d ev=%0h data=%h cnt=%0d last=%0d, got kind=%0d st=%0d ev=%0h data=%h cnt=%0d last=%0d",
				$time, what, want.kind, want.status, want.event_mask, want.event_data,
				want.event_count, want.last, got.kind, got.status, got.event_mask,
				got.event_data, got.event_count, got.last);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (answers_q.size() == 0) begin
				log_mismatch("unexpected word", '0, result);
			end else begin
				head = answers_q.pop_front();
				if (result.kind !== head.kind || result.status !== head.status
						|| result.event_mask !== head.event_mask
						|| result.event_data !== head.event_data
						|| result.event_count !== head.event_count
						|| result.last !== head.last)
					log_mismatch("mismatch", head, result);
			end
		end
	end

	function automatic eit_cmd_t rand_word();
		eit_cmd_t w;
		w.action = 3'($urandom_range(0, 7));
		w.fd = 6'($urandom);
		w.fd_open = 1'($urandom);
		w.want_events = $urandom;
		w.user_data = {$urandom, $urandom};
		w.readable_map = {$urandom, $urandom};
		w.writable_map = {$urandom, $urandom};
		w.max_events = 6'($urandom);
		return w;
	endfunction

	function automatic eit_cmd_t keyed(logic [2:0] act, logic [5:0] fd, logic open,
			logic [31:0] want, logic [63:0] data);
		eit_cmd_t w;
		w = rand_word();
		w.action = act;
		w.fd = fd;
		w.fd_open = open;
		w.want_events = want;
		w.user_data = data;
		return w;
	endfunction

	function automatic eit_cmd_t scan_of(logic [63:0] rmap, logic [63:0] wmap,
			logic [5:0] maxev);
		eit_cmd_t w;
		w = rand_word();
		w.action = ACT_SCAN;
		w.readable_map = rmap;
		w.writable_map = wmap;
		w.max_events = maxev;
		return w;
	endfunction

	function automatic logic [63:0] rand_map();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return {$urandom, $urandom};
		if (r < 7)
			return {$urandom, $urandom} | {$urandom, $urandom};
		return {$urandom, $urandom} & {$urandom, $urandom};
	endfunction

	function automatic logic [5:0] rand_max();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 6'd0;
		if (r < 25)
			return 6'($urandom_range(33, 63));
		if (r < 50)
			return 6'($urandom_range(1, 3));
		return 6'($urandom_range(1, 32));
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic plan_word(eit_cmd_t w, bit calm);
		job_t j;
		j.op = JOB_WORD;
		j.word = w;
		j.gap = pick_gap(calm);
		j.reg_val = '0;
		jobs_q.push_back(j);
	endtask

	task automatic plan_setting(job_op_t op, logic [5:0] fd);
		job_t j;
		j.op = op;
		j.word = '0;
		j.gap = 0;
		j.reg_val = {26'($urandom), fd};
		jobs_q.push_back(j);
	endtask

	initial begin
		eit_cmd_t w;
		int r;
		int fd_hi;
		int add_w;
		int del_w;
		bit calm;

		for (int i = 0; i < SLOTS_DEF; i++) begin
			slot_valid[i] = 1'b0;
			slot_fd[i] = '0;
			slot_mask[i] = '0;
			slot_data[i] = '0;
		end
		own_fd_now = '0;

		plan_word(scan_of('1, '1, 6'd1), 0);
		plan_word(scan_of('1, '1, 6'd0), 0);
		plan_word(keyed(ACT_ADD, 6'd0, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(ACT_ADD, 6'd0, 1'b0, 32'h5, '1), 0);
		plan_word(keyed(ACT_ADD, 6'd5, 1'b0, 32'h5, '1), 0);
		plan_word(keyed(ACT_ADD, 6'd5, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(ACT_ADD, 6'd5, 1'b1, 32'h1, '0), 0);
		plan_word(keyed(ACT_ADD, 6'd63, 1'b1, 32'hFFFF_FFFF, '0), 0);
		plan_word(keyed(ACT_ADD, 6'd1, 1'b1, 32'h1, 64'h0123_4567_89AB_CDEF), 0);
		plan_word(keyed(ACT_ADD, 6'd2, 1'b1, 32'hFFFF_FFFA, 64'hDEAD_BEEF_0000_0002), 0);
		plan_word(keyed(ACT_MOD, 6'd9, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(ACT_DEL, 6'd9, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(ACT_MOD, 6'd1, 1'b1, 32'h4, 64'hFEDC_BA98_7654_3210), 0);
		plan_word(keyed(ACT_UNSUP, 6'd3, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(3'd7, 6'd3, 1'b0, 32'h5, '1), 0);
		plan_word(keyed(3'd5, 6'd3, 1'b1, 32'h5, '1), 0);
		plan_word(keyed(3'd6, 6'd3, 1'b1, 32'h5, '1), 0);
		plan_word(scan_of('1, '1, 6'd63), 0);
		plan_word(scan_of('1, '1, 6'd1), 0);
		plan_word(scan_of('1, '0, 6'd32), 0);
		plan_word(scan_of('0, '1, 6'd32), 0);
		plan_word(scan_of('0, '0, 6'd32), 0);
		plan_word(keyed(ACT_DEL, 6'd5, 1'b1, '0, '0), 0);
		plan_word(keyed(ACT_DEL, 6'd5, 1'b1, '0, '0), 0);
		plan_word(scan_of('1, '1, 6'd32), 0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: plan_setting(JOB_OWN_FD, 6'd63);
			1: plan_setting(JOB_OWN_FD, 6'd0);
			2: plan_setting(JOB_OWN_FD, 6'($urandom_range(0, 15)));
			default: plan_setting(JOB_OWN_FD, 6'($urandom_range(0, 63)));
			endcase
			fd_hi = (p == 0 || p == 2 || p == 7) ? 15 : 63;
			add_w = (p == 3 || p == 4) ? 55 : (p == 6) ? 10 : 30;
			del_w = (p == 3 || p == 4) ? 4 : (p == 6) ? 45 : 15;
			calm = (p == 2);
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (k == PHASE_LEN / 2)
					plan_setting(JOB_DRAIN, '0);
				w = rand_word();
				w.fd = 6'($urandom_range(0, fd_hi));
				w.fd_open = ($urandom_range(0, 99) < 92);
				r = $urandom_range(0, 99);
				if (r < 30) begin
					w.action = ACT_SCAN;
					w.readable_map = rand_map();
					w.writable_map = rand_map();
					w.max_events = rand_max();
				end else if (r < 33) begin
					w.action = 3'($urandom_range(ACT_UNSUP, 7));
				end else if (r < 33 + add_w) begin
					w.action = ACT_ADD;
				end else if (r < 33 + add_w + del_w) begin
					w.action = ACT_DEL;
				end else begin
					w.action = ACT_MOD;
				end
				plan_word(w, calm);
			end
		end
		plan_setting(JOB_OWN_FD, 6'd0);
		plan_word(scan_of('1, '1, 6'd32), 0);

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (jobs_q.size() != 0 || start || busy || answers_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
